[design/smf_pkg.sv]
package smf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int VALUE_W      = 17;
  localparam int CH_W         = 2;
  localparam int WINDOW_DEF   = 5;
  localparam int CHANNELS_DEF = 3;

  // APB register map: register index sits in paddr[2]
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FILTER_ENABLE = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                read_ok;
    logic                prime;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_twice;
    logic               valid_res;
  } out_t;

  // what one sorting cell shows its right-hand neighbor
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                valid;
    logic                stays;
  } link_t;

endpackage

[design/sliding_median_filter_core.sv]
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------
// input    | in        | in_valid_i / in_stall_o | in_data_i  (smf_pkg::in_t)
// output   | out       | out_valid_o / out_stall_i| out_data_o (smf_pkg::out_t)
// config   | in/out    | APB psel/penable/pready | filter_enable at byte 0
//
// After acceptance a median transaction stores the sample, streams the
// channel's window through the row of sorting cells (one sample a cycle) and
// loads the output register before the next input can be taken. Pass-through
// and invalid results go from acceptance straight to the output register load.
// Reset clears every window entry to zero, all write slots and filter_enable.
// A stalled output holds its result; the next input is still accepted and
// processed, and waits in the done state until the output register frees up.
module sliding_median_filter_core #(
  parameter int WINDOW   = smf_pkg::WINDOW_DEF,
  parameter int CHANNELS = smf_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  smf_pkg::in_t                  in_data_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output smf_pkg::out_t                 out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smf_pkg::PADDR_W-1:0]   paddr,
  input  logic [smf_pkg::PDATA_W-1:0]   pwdata,
  output logic [smf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MID   = WINDOW / 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SORT = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic en_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == smf_pkg::REG_FILTER_ENABLE)) begin
      en_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == smf_pkg::REG_FILTER_ENABLE) begin
      prdata[0] = en_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic            accept;
  logic            ch_ok;
  logic            do_store;
  logic            do_median;
  logic [CI_W-1:0] ch_idx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign ch_ok      = in_data_i.read_ok && (int'(in_data_i.channel) < CHANNELS);
  assign do_store   = ch_ok && (in_data_i.prime || en_q);
  assign do_median  = ch_ok && !in_data_i.prime && en_q;
  assign ch_idx     = CI_W'(in_data_i.channel);

  // ---------------------------------------------------------------------------
  // Sample windows and write slots
  // ---------------------------------------------------------------------------
  logic [smf_pkg::SAMPLE_W-1:0] win_q  [CHANNELS][WINDOW];
  logic [IDX_W-1:0]             slot_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        slot_q[c] <= '0;
        for (int w = 0; w < WINDOW; w++) begin
          win_q[c][w] <= '0;
        end
      end
    end else if (accept && do_store) begin
      // overwrite the oldest slot, then advance and wrap
      win_q[ch_idx][slot_q[ch_idx]] <= in_data_i.sample;
      if (slot_q[ch_idx] == LAST_IDX) begin
        slot_q[ch_idx] <= '0;
      end else begin
        slot_q[ch_idx] <= slot_q[ch_idx] + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [CI_W-1:0]  ch_q;
  logic [IDX_W-1:0] idx_q;
  logic             med_q;
  smf_pkg::out_t    res_q;
  logic             out_free;

  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = do_median ? ST_SORT : ST_DONE;
        end
      end
      ST_SORT: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == ST_SORT) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // latch the transaction's channel and pass-through result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= ch_idx;
      med_q <= do_median;
      if (ch_ok) begin
        res_q.value_twice <= {in_data_i.sample, 1'b0};
        res_q.valid_res   <= 1'b1;
      end else begin
        res_q.value_twice <= '0;
        res_q.valid_res   <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row of sorting cells: each cycle in the sort state one window sample is
  // inserted; cells keep ascending order, so after WINDOW inserts cell k holds the (k+1)-th smallest.
  // ---------------------------------------------------------------------------
  smf_pkg::link_t               link [WINDOW];
  logic [smf_pkg::SAMPLE_W-1:0] feed;
  logic                         shift;

  assign feed  = win_q[ch_q][idx_q];
  assign shift = (state_q == ST_SORT);

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    smf_pkg::link_t left;
    if (k == 0) begin : g_head
      assign left = '{value: '0, valid: 1'b1, stays: 1'b1};
    end else begin : g_body
      assign left = link[k-1];
    end
    smf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (accept),
      .shift_i (shift),
      .x_i     (feed),
      .left_i  (left),
      .link_o  (link[k])
    );
  end

  // doubled median: twice the middle, or the sum of the two middle values
  logic [smf_pkg::VALUE_W-1:0] median2;
  if ((WINDOW % 2) == 0) begin : g_even
    assign median2 = {1'b0, link[MID-1].value} + {1'b0, link[MID].value};
  end else begin : g_odd
    assign median2 = {link[MID].value, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic          out_valid_q;
  smf_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      if (med_q) begin
        out_q.value_twice <= median2;
        out_q.valid_res   <= 1'b1;
      end else begin
        out_q <= res_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/smf_cell.sv]
module smf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          shift_i,
  input  logic [smf_pkg::SAMPLE_W-1:0]  x_i,
  input  smf_pkg::link_t                left_i,
  output smf_pkg::link_t                link_o
);

  logic [smf_pkg::SAMPLE_W-1:0] value_q;
  logic                         valid_q;
  logic                         stays;

  // a filled cell holding a value no larger than x keeps it
  assign stays = valid_q && (value_q <= x_i);

  always_ff @(posedge clk_i) begin
    if (shift_i && !stays) begin
      value_q <= left_i.stays ? x_i : left_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i && !stays) begin
      valid_q <= left_i.stays | left_i.valid;
    end
  end

  assign link_o = '{value: value_q, valid: valid_q, stays: stays};

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = smf_pkg::WINDOW_DEF;
  localparam int CHN          = smf_pkg::CHANNELS_DEF;
  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * (WIN + 2);
  localparam logic [smf_pkg::PADDR_W-1:0] FILTER_ENABLE_ADDR =
    {smf_pkg::REG_FILTER_ENABLE, 2'b00};

  // one line of the directed table: either a register write or a sample
  // transaction, the latter with an optional hand-written expectation
  typedef struct packed {
    logic          cfg;
    logic          en;
    logic          known;
    smf_pkg::in_t  item;
    smf_pkg::out_t want;
  } stim_row_t;

  logic                         clk;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  smf_pkg::in_t                 in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  smf_pkg::out_t                out_data_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [smf_pkg::PADDR_W-1:0]  paddr;
  logic [smf_pkg::PDATA_W-1:0]  pwdata;
  logic [smf_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // shadow of the block: per-channel ring windows, write slots, enable bit
  logic [smf_pkg::SAMPLE_W-1:0] win_mem [CHN][WIN];
  logic [2:0]                   slot_ptr [CHN];
  logic                         filt_en_model;

  smf_pkg::out_t                twice_median_q [$];
  stim_row_t                    dir_tab [$];
  int                           mismatch_cnt;
  int                           burst_left;
  bit                           hold_req;
  bit                           typed_known;
  smf_pkg::out_t                typed_want;

  sliding_median_filter_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatch_cnt++;
  endtask

  // Update the shadow windows for one accepted transaction and return the
  // doubled median (or doubled sample on pass-through).
  function automatic smf_pkg::out_t predict_twice_median(input smf_pkg::in_t it);
    logic [smf_pkg::SAMPLE_W-1:0] srt [WIN];
    logic [smf_pkg::SAMPLE_W-1:0] t;
    int                           ch;
    int                           slot;
    smf_pkg::out_t                r;
    ch = int'(it.channel);
    r  = '0;
    if (it.read_ok && ch < CHN) begin
      r.valid_res = 1'b1;
      if (it.prime || filt_en_model) begin
        slot = int'(slot_ptr[ch]);
        if (slot >= WIN) slot = 0;
        win_mem[ch][slot] = it.sample;
        slot_ptr[ch] = (slot + 1 >= WIN) ? 3'd0 : 3'(slot + 1);
      end
      if (it.prime || !filt_en_model) begin
        r.value_twice = {1'b0, it.sample} << 1;
      end else begin
        for (int i = 0; i < WIN; i++) srt[i] = win_mem[ch][i];
        for (int i = 0; i + 1 < WIN; i++) begin
          for (int j = 0; j + 1 < WIN - i; j++) begin
            if (srt[j] > srt[j+1]) begin
              t = srt[j];
              srt[j] = srt[j+1];
              srt[j+1] = t;
            end
          end
        end
        if (WIN % 2 == 0)
          r.value_twice = smf_pkg::VALUE_W'(srt[WIN/2-1]) + smf_pkg::VALUE_W'(srt[WIN/2]);
        else
          r.value_twice = smf_pkg::VALUE_W'(srt[WIN/2]) << 1;
      end
    end
    return r;
  endfunction

  // Mostly well-formed reads on valid channels; a share of failed reads,
  // the unused channel code and prime requests. Counts lean toward the
  // extremes and toward small values so that ties show up in the window.
  function automatic smf_pkg::in_t random_reading();
    smf_pkg::in_t it;
    it.channel = ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, CHN - 1));
    it.read_ok = ($urandom_range(0, 99) >= 7);
    it.prime   = ($urandom_range(0, 99) < 10);
    case ($urandom_range(0, 9))
      0:       it.sample = '0;
      1:       it.sample = '1;
      2, 3, 4: it.sample = 16'($urandom_range(0, 15));
      5:       it.sample = 16'h8000 + 16'($urandom_range(0, 7));
      default: it.sample = 16'($urandom);
    endcase
    return it;
  endfunction

  function automatic stim_row_t mk_row(input bit cfg, input bit en, input bit [1:0] ch,
                                       input bit [15:0] smp, input bit ok, input bit pr,
                                       input bit known, input bit [16:0] val,
                                       input bit vres);
    stim_row_t r;
    r.cfg              = cfg;
    r.en               = en;
    r.known            = known;
    r.item.channel     = ch;
    r.item.sample      = smp;
    r.item.read_ok     = ok;
    r.item.prime       = pr;
    r.want.value_twice = val;
    r.want.valid_res   = vres;
    return r;
  endfunction

  // Offer one transaction on the input side. Work in bursts: at the end of
  // a burst drop valid for a random gap (sometimes none), then start a new
  // burst. Valid stays high across back-to-back transactions.
  task automatic send(input smf_pkg::in_t it, input bit known, input smf_pkg::out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_data_i   <= it;
    in_valid_i  <= 1'b1;
    typed_known = known;
    typed_want  = want;
    do @(posedge clk); while (in_stall_o);
  endtask

  // Write filter_enable over APB once the block has drained, then read it
  // back. The shadow copy follows the write.
  task automatic write_filter_enable(input bit en);
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (twice_median_q.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= FILTER_ENABLE_ADDR;
    pwdata  <= smf_pkg::PDATA_W'(en);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    filt_en_model = en;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== smf_pkg::PDATA_W'(en))
      log_mismatch("filter_enable readback", prdata, 32'(en));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver: stall in segments of its own pattern (free flowing, random,
  // or periodic). On request, hold off for a long stretch so that the
  // block fills up and pushes back on the sender.
  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall_i <= 1'b1;
        end
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(5, 60);
      for (int k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= (k % 3 == 0);
        endcase
      end
    end
  end

  // Scoreboard: advance the shadow on every accepted input transaction,
  // then compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    smf_pkg::out_t got;
    smf_pkg::out_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        exp_r = predict_twice_median(in_data_i);
        if (typed_known) exp_r = typed_want;
        twice_median_q.push_back(exp_r);
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (twice_median_q.size() == 0) begin
          log_mismatch("unexpected result", 32'(got), 0);
        end else begin
          exp_r = twice_median_q.pop_front();
          if (got.value_twice !== exp_r.value_twice)
            log_mismatch("value_twice", 32'(got.value_twice), 32'(exp_r.value_twice));
          if (got.valid_res !== exp_r.valid_res)
            log_mismatch("valid_res", 32'(got.valid_res), 32'(exp_r.valid_res));
        end
      end
    end
  end

  initial begin
    smf_pkg::in_t it;
    mismatch_cnt = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    typed_known  = 1'b0;
    typed_want   = '0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    // shadow reset: empty windows, slots at zero, filtering off
    for (int c = 0; c < CHN; c++) begin
      for (int i = 0; i < WIN; i++) win_mem[c][i] = '0;
      slot_ptr[c] = '0;
    end
    filt_en_model = 1'b0;

    //                  cfg en ch  sample    ok pr known value      vres
    // filtering off after reset: pass-through at the extremes
    dir_tab.push_back(mk_row(0, 0, 0, 16'hFFFF, 1, 0, 1, 17'h1FFFE, 1));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0000, 1, 0, 1, 17'h00000, 1));
    dir_tab.push_back(mk_row(0, 0, 2, 16'h8001, 1, 0, 1, 17'h10002, 1));
    // failed read, unused channel code (plain and with prime)
    dir_tab.push_back(mk_row(0, 0, 1, 16'h1234, 0, 0, 1, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 3, 16'hFFFF, 1, 0, 1, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 3, 16'h5555, 1, 1, 1, 17'h00000, 0));
    // prime stores even with filtering off
    dir_tab.push_back(mk_row(0, 0, 2, 16'hABCD, 1, 1, 1, 17'h1579A, 1));
    dir_tab.push_back(mk_row(1, 1, 0, 16'h0000, 0, 0, 0, 17'h00000, 0));
    // medians: partly filled windows, then the top of the range
    dir_tab.push_back(mk_row(0, 0, 2, 16'h0001, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 16'hFFFF, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 16'hFFFF, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 16'hFFFF, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 16'h7FFF, 1, 0, 0, 17'h00000, 0));
    // failed read, prime and unused channel while filtering
    dir_tab.push_back(mk_row(0, 0, 0, 16'hFFFF, 0, 0, 1, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0042, 1, 1, 1, 17'h00084, 1));
    dir_tab.push_back(mk_row(0, 0, 3, 16'h0000, 1, 0, 1, 17'h00000, 0));
    // run a channel past the end of its ring
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0005, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0003, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0009, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0001, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0007, 1, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0002, 1, 0, 0, 17'h00000, 0));
    // off again: pass-through leaves the window alone
    dir_tab.push_back(mk_row(1, 0, 0, 16'h0000, 0, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'h0010, 1, 0, 1, 17'h00020, 1));
    dir_tab.push_back(mk_row(1, 1, 0, 16'h0000, 0, 0, 0, 17'h00000, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 16'hFFFF, 1, 0, 0, 17'h00000, 0));

    // hold reset, then release it at a falling edge, away from the rising edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].cfg)
        write_filter_enable(dir_tab[k].en);
      else
        send(dir_tab[k].item, dir_tab[k].known, dir_tab[k].want);
    end

    // Random phases: filtering on, off, on with a long receiver hold, on.
    // Each filtering phase opens with a warm-up that primes every window.
    for (int ph = 0; ph < 4; ph++) begin
      write_filter_enable(ph != 1);
      if (ph == 2) hold_req = 1'b1;
      if (ph != 1) begin
        for (int c = 0; c < CHN; c++) begin
          repeat (WIN) begin
            it         = random_reading();
            it.channel = 2'(c);
            it.read_ok = 1'b1;
            it.prime   = 1'b1;
            send(it, 1'b0, '0);
          end
        end
      end
      repeat (PHASE_ITEMS) send(random_reading(), 1'b0, '0);
    end

    // drain: wait for every result, then a margin for stray output
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (twice_median_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
design/smf_pkg.sv
design/smf_cell.sv
design/sliding_median_filter_core.sv
tb/tb_top.sv
